@@ rtl/core/hrdm_pkg.sv @@
`timescale 1ns / 1ps
// Package for the Hamming ratio descriptor matcher.
// Holds field widths, reset values, command and register codes. No dependencies.
package hrdm_pkg;

    localparam int DESC_W       = 64;
    localparam int DESC_WORDS   = 4;
    localparam int DESC_BITS    = DESC_W * DESC_WORDS;
    localparam int DIST_W       = 9;
    localparam int IDX_W        = 12;
    localparam int CFG_ADDR_W   = 1;
    localparam int CFG_DATA_W   = 9;
    localparam int MAX_FEATURES = 4096;

    localparam logic [DIST_W-1:0]     DIST_INIT      = DIST_W'(DESC_BITS);
    localparam logic [CFG_DATA_W-1:0] MAX_DIST_RESET = CFG_DATA_W'(50);
    localparam logic [CFG_DATA_W-1:0] RATIO_RESET    = CFG_DATA_W'(192);

    // Command carried with each input word
    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_CAND = 1'b1
    } t_cmd;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_MAX_DIST = 1'b0,
        REG_RATIO    = 1'b1
    } t_reg;

endpackage

@@ rtl/core/hamming_ratio_descriptor_matcher.sv @@
`timescale 1ns / 1ps
// Hamming ratio descriptor matcher: top level. Uses hrdm_pkg and hrdm_popcnt.
// A result word passes from the input register through the raw result stage to the
// output register and o_valid. One input word per cycle while o_stall is low; the bests feedback loop
// (popcount, compare, update) has no pipeline register inside it.
// Reset (synchronous, active low): query zero, bests cleared, registers to
// max_distance 50 and ratio_q8 192, pipeline empty.
module hamming_ratio_descriptor_matcher
    import hrdm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_command,
    input  logic [DESC_W-1:0]     i_desc_word0,
    input  logic [DESC_W-1:0]     i_desc_word1,
    input  logic [DESC_W-1:0]     i_desc_word2,
    input  logic [DESC_W-1:0]     i_desc_word3,
    input  logic [IDX_W-1:0]      i_cand_index,
    input  logic                  i_cand_taken,
    input  logic                  i_last,
    // output channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_match_found,
    output logic [IDX_W-1:0]      o_match_index,
    output logic [DIST_W-1:0]     o_best_distance,
    output logic [DIST_W-1:0]     o_second_distance
);

    // Configuration registers
    logic [CFG_DATA_W-1:0] r_max_dist, r_ratio;

    // Input register
    logic                 r_in_valid;
    t_cmd                 r_in_cmd;
    logic [DESC_BITS-1:0] r_in_desc;
    logic [IDX_W-1:0]     r_in_index;
    logic                 r_in_taken;
    logic                 r_in_last;

    // Query and running bests
    logic [DESC_BITS-1:0] r_query;
    logic [DIST_W-1:0]    r_best, r_second;
    logic [IDX_W-1:0]     r_best_idx;
    logic                 r_best_valid;
    logic [DIST_W-1:0]    n_best, n_second;
    logic [IDX_W-1:0]     n_best_idx;
    logic                 n_best_valid;

    // Raw result stage
    logic                 r_res_valid;
    logic [DIST_W-1:0]    r_res_best, r_res_second;
    logic [IDX_W-1:0]     r_res_idx;
    logic                 r_res_has;

    // Output register
    logic                 r_out_valid;
    logic                 r_out_found;
    logic [IDX_W-1:0]     r_out_idx;
    logic [DIST_W-1:0]    r_out_best, r_out_second;

    logic                 in_take, fire, is_result, res_ready, out_ready;
    logic                 eligible;
    logic [DIST_W-1:0]    cand_dist;
    logic                 ok;
    logic [DIST_W+7:0]    best_scaled;
    logic [DIST_W+CFG_DATA_W-1:0] ratio_prod;

    // Handshake: each stage moves when the one after it can take its word
    assign out_ready = !r_out_valid || !i_stall;
    assign res_ready = !r_res_valid || out_ready;
    assign is_result = (r_in_cmd == CMD_CAND) && r_in_last;
    assign fire      = r_in_valid && (!is_result || res_ready);
    assign o_stall   = r_in_valid && !fire;
    assign in_take   = i_valid && !o_stall;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_dist <= MAX_DIST_RESET;
            r_ratio    <= RATIO_RESET;
        end else if (i_cfg_we) begin
            unique case (t_reg'(i_cfg_addr))
                REG_MAX_DIST: r_max_dist <= i_cfg_data;
                REG_RATIO:    r_ratio    <= i_cfg_data;
            endcase
        end
    end

    // Capture the input word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_cmd   <= t_cmd'(i_command);
            r_in_desc  <= {i_desc_word3, i_desc_word2, i_desc_word1, i_desc_word0};
            r_in_index <= i_cand_index;
            r_in_taken <= i_cand_taken;
            r_in_last  <= i_last;
        end
    end

    hrdm_popcnt u_popcnt (
        .i_query (r_query),
        .i_desc  (r_in_desc),
        .o_dist  (cand_dist)
    );

    // Update the bests with this candidate's distance
    assign eligible = !r_in_taken && (32'(r_in_index) < MAX_FEATURES);

    always_comb begin
        n_best       = r_best;
        n_second     = r_second;
        n_best_idx   = r_best_idx;
        n_best_valid = r_best_valid;
        if (eligible) begin
            if (cand_dist < r_best) begin
                n_second     = r_best;
                n_best       = cand_dist;
                n_best_idx   = r_in_index;
                n_best_valid = 1'b1;
            end else if (cand_dist < r_second) begin
                n_second = cand_dist;
            end
        end
    end

    // Query and bests; clear bests on a load and after the last candidate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query      <= '0;
            r_best       <= DIST_INIT;
            r_second     <= DIST_INIT;
            r_best_idx   <= '0;
            r_best_valid <= 1'b0;
        end else if (fire) begin
            if (r_in_cmd == CMD_LOAD || r_in_last) begin
                r_best       <= DIST_INIT;
                r_second     <= DIST_INIT;
                r_best_idx   <= '0;
                r_best_valid <= 1'b0;
            end else begin
                r_best       <= n_best;
                r_second     <= n_second;
                r_best_idx   <= n_best_idx;
                r_best_valid <= n_best_valid;
            end
            if (r_in_cmd == CMD_LOAD) begin
                r_query <= r_in_desc;
            end
        end
    end

    // Raw result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (fire && is_result) begin
            r_res_valid <= 1'b1;
        end else if (out_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && is_result) begin
            r_res_best   <= n_best;
            r_res_second <= n_second;
            r_res_idx    <= n_best_valid ? n_best_idx : '0;
            r_res_has    <= n_best_valid;
        end
    end

    // Threshold and ratio test
    assign best_scaled = {r_res_best, 8'd0};
    assign ratio_prod  = (DIST_W+CFG_DATA_W)'(r_ratio) * (DIST_W+CFG_DATA_W)'(r_res_second);
    assign ok = r_res_has && (r_res_best <= r_max_dist)
                && ((DIST_W+CFG_DATA_W)'(best_scaled) < ratio_prod);

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_res_valid) begin
            r_out_found  <= ok;
            r_out_idx    <= r_res_idx;
            r_out_best   <= r_res_best;
            r_out_second <= r_res_second;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_match_found     = r_out_found;
    assign o_match_index     = r_out_idx;
    assign o_best_distance   = r_out_best;
    assign o_second_distance = r_out_second;

endmodule

@@ rtl/core/hrdm_popcnt.sv @@
`timescale 1ns / 1ps
// Hamming distance between two 256-bit descriptors: XOR and popcount tree.
// Depends on hrdm_pkg for widths.
module hrdm_popcnt
    import hrdm_pkg::*;
(
    input  logic [DESC_BITS-1:0] i_query,
    input  logic [DESC_BITS-1:0] i_desc,
    output logic [DIST_W-1:0]    o_dist
);

    localparam int NBYTES = DESC_BITS / 8;

    logic [DESC_BITS-1:0] diff;
    logic [3:0] cnt_l0 [NBYTES];
    logic [4:0] cnt_l1 [NBYTES/2];
    logic [5:0] cnt_l2 [NBYTES/4];
    logic [6:0] cnt_l3 [NBYTES/8];
    logic [7:0] cnt_l4 [NBYTES/16];

    assign diff = i_query ^ i_desc;

    // Count ones in each byte
    always_comb begin
        for (int b = 0; b < NBYTES; b++) begin
            cnt_l0[b] = 4'd0;
            for (int k = 0; k < 8; k++) begin
                cnt_l0[b] = cnt_l0[b] + 4'(diff[b*8+k]);
            end
        end
    end

    // Add up the byte counts pairwise
    always_comb begin
        for (int j = 0; j < NBYTES/2; j++) begin
            cnt_l1[j] = 5'(cnt_l0[2*j]) + 5'(cnt_l0[2*j+1]);
        end
        for (int j = 0; j < NBYTES/4; j++) begin
            cnt_l2[j] = 6'(cnt_l1[2*j]) + 6'(cnt_l1[2*j+1]);
        end
        for (int j = 0; j < NBYTES/8; j++) begin
            cnt_l3[j] = 7'(cnt_l2[2*j]) + 7'(cnt_l2[2*j+1]);
        end
        for (int j = 0; j < NBYTES/16; j++) begin
            cnt_l4[j] = 8'(cnt_l3[2*j]) + 8'(cnt_l3[2*j+1]);
        end
    end

    assign o_dist = DIST_W'(cnt_l4[0]) + DIST_W'(cnt_l4[1]);

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// Testbench for hamming_ratio_descriptor_matcher: directed table, then random query groups.
// Depends on hrdm_pkg and the matcher RTL; checks every result word, predicted or typed.

module tb;
    import hrdm_pkg::*;

    // One input word and one result word
    typedef struct {
        t_cmd               cmd;
        logic [DESC_BITS-1:0] desc;
        logic [IDX_W-1:0]   idx;
        logic               taken;
        logic               last;
    } t_desc_word;

    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  idx;
        logic [DIST_W-1:0] best;
        logic [DIST_W-1:0] second;
    } t_match;

    // Directed row: word plus an optional hand-written result
    typedef struct {
        t_desc_word w;
        bit         typed;
        t_match     want;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_stall;
    logic                  i_command;
    logic [DESC_W-1:0]     i_desc_word0;
    logic [DESC_W-1:0]     i_desc_word1;
    logic [DESC_W-1:0]     i_desc_word2;
    logic [DESC_W-1:0]     i_desc_word3;
    logic [IDX_W-1:0]      i_cand_index;
    logic                  i_cand_taken;
    logic                  i_last;
    logic                  o_valid;
    logic                  i_stall;
    logic                  o_match_found;
    logic [IDX_W-1:0]      o_match_index;
    logic [DIST_W-1:0]     o_best_distance;
    logic [DIST_W-1:0]     o_second_distance;

    hamming_ratio_descriptor_matcher i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_command         (i_command),
        .i_desc_word0      (i_desc_word0),
        .i_desc_word1      (i_desc_word1),
        .i_desc_word2      (i_desc_word2),
        .i_desc_word3      (i_desc_word3),
        .i_cand_index      (i_cand_index),
        .i_cand_taken      (i_cand_taken),
        .i_last            (i_last),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_match_found     (o_match_found),
        .o_match_index     (o_match_index),
        .o_best_distance   (o_best_distance),
        .o_second_distance (o_second_distance)
    );

    // Predictor state: query, running bests and registers
    logic [DESC_BITS-1:0]  held_query;
    logic [DIST_W-1:0]     near_dist;
    logic [DIST_W-1:0]     runner_dist;
    logic [IDX_W-1:0]      near_idx;
    bit                    near_seen;
    logic [CFG_DATA_W-1:0] lim_dist;
    logic [CFG_DATA_W-1:0] lim_ratio;

    t_match   pending_matches[$];
    t_dir_row dir_tab[$];
    int       n_errors;
    int       n_words;
    int       n_results;
    int       n_found;
    int       n_settings;
    bit       in_idle_on;
    bit       out_idle_on;

    // Clock: 10 ns period
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop
    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic void clear_bests();
        near_dist   = DIST_INIT;
        runner_dist = DIST_INIT;
        near_idx    = '0;
        near_seen   = 1'b0;
    endfunction

    // Advance the predictor by one accepted word; return 1 when a result follows
    function automatic bit match_predict(input t_desc_word w, output t_match r);
        logic [DIST_W-1:0] d;
        r = '0;
        if (w.cmd == CMD_LOAD) begin
            held_query = w.desc;
            clear_bests();
            return 1'b0;
        end
        if (!w.taken && int'(w.idx) < MAX_FEATURES) begin
            d = DIST_W'($countones(held_query ^ w.desc));
            if (d < near_dist) begin
                runner_dist = near_dist;
                near_dist   = d;
                near_idx    = w.idx;
                near_seen   = 1'b1;
            end else if (d < runner_dist) begin
                runner_dist = d;
            end
        end
        if (!w.last)
            return 1'b0;
        r.found  = near_seen && near_dist <= lim_dist &&
                   int'(near_dist) * 256 < int'(lim_ratio) * int'(runner_dist);
        r.idx    = near_seen ? near_idx : '0;
        r.best   = near_dist;
        r.second = runner_dist;
        clear_bests();
        return 1'b1;
    endfunction

    function automatic logic [DESC_BITS-1:0] rand_desc();
        logic [DESC_BITS-1:0] v;
        for (int i = 0; i < DESC_BITS / 32; i++)
            v[i*32 +: 32] = $urandom();
        return v;
    endfunction

    // Candidate at exactly k bits from the held query
    function automatic logic [DESC_BITS-1:0] near_desc(input int k);
        logic [DESC_BITS-1:0] m;
        m = '0;
        while ($countones(m) < k)
            m[$urandom_range(0, DESC_BITS - 1)] = 1'b1;
        return held_query ^ m;
    endfunction

    // Drive one word after a random gap, hold it until accepted, then predict
    task automatic send_word(input t_desc_word w, input bit typed, input t_match want);
        int     gap;
        t_match r;
        gap = in_idle_on ? $urandom_range(0, 15) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid      <= 1'b1;
        i_command    <= w.cmd;
        i_desc_word0 <= w.desc[63:0];
        i_desc_word1 <= w.desc[127:64];
        i_desc_word2 <= w.desc[191:128];
        i_desc_word3 <= w.desc[255:192];
        i_cand_index <= w.idx;
        i_cand_taken <= w.taken;
        i_last       <= w.last;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        if (match_predict(w, r))
            pending_matches = {pending_matches, (typed ? want : r)};
        n_words++;
        if (n_words % 50 == 0)
            in_idle_on = ($urandom_range(0, 3) != 0);
    endtask

    // Wait for outstanding results, then let the pipeline empty
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        for (int c = 0; c < 5000 && pending_matches.size() > 0; c++)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // Write both registers back to back while the block is idle
    task automatic set_limits(input logic [CFG_DATA_W-1:0] md, input logic [CFG_DATA_W-1:0] rq);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= REG_MAX_DIST;
        i_cfg_data <= md;
        lim_dist = md;
        @(negedge i_clk);
        i_cfg_addr <= REG_RATIO;
        i_cfg_data <= rq;
        lim_ratio = rq;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    // Random groups: an optional load, candidates, last; some broken by a stray load
    task automatic run_groups(input int budget);
        t_desc_word w;
        int         start;
        int         len;
        int         sel;
        start = n_words;
        while (n_words - start < budget) begin
            if ($urandom_range(0, 3) == 0) begin
                w.cmd   = CMD_LOAD;
                w.desc  = rand_desc();
                w.idx   = IDX_W'($urandom());
                w.taken = 1'($urandom_range(0, 1));
                w.last  = 1'($urandom_range(0, 1));
                send_word(w, 1'b0, '0);
            end
            len = $urandom_range(1, 12);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 15) == 0) begin
                    w.cmd   = CMD_LOAD;
                    w.desc  = rand_desc();
                    w.idx   = IDX_W'($urandom());
                    w.taken = 1'($urandom_range(0, 1));
                    w.last  = 1'($urandom_range(0, 1));
                    send_word(w, 1'b0, '0);
                end
                sel = $urandom_range(0, 9);
                w.cmd = CMD_CAND;
                if (sel < 7)
                    w.desc = near_desc($urandom_range(0, 70));
                else if (sel < 9)
                    w.desc = rand_desc();
                else
                    w.desc = near_desc($urandom_range(200, DESC_BITS));
                case ($urandom_range(0, 15))
                    0:       w.idx = '0;
                    1:       w.idx = '1;
                    default: w.idx = IDX_W'($urandom());
                endcase
                w.taken = ($urandom_range(0, 7) == 0);
                w.last  = (k == len - 1);
                send_word(w, 1'b0, '0);
            end
        end
    endtask

    // Result side: stall a random number of cycles, then take one word
    initial begin
        int n;
        int taken_cnt;
        taken_cnt = 0;
        out_idle_on = 1'b1;
        i_stall = 1'b0;
        forever begin
            n = out_idle_on ? $urandom_range(0, 15) : 0;
            repeat (n) begin
                @(negedge i_clk);
                i_stall <= 1'b1;
            end
            @(negedge i_clk);
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(i_rst_n === 1'b1 && o_valid === 1'b1));
            taken_cnt++;
            if (taken_cnt % 32 == 0)
                out_idle_on = ($urandom_range(0, 3) != 0);
        end
    end

    // Compare each accepted result word with the oldest expectation
    always @(posedge i_clk) begin
        t_match want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_matches.size() == 0) begin
                $error("unexpected result word: found %0d index %0d best %0d second %0d",
                       o_match_found, o_match_index, o_best_distance, o_second_distance);
                n_errors++;
            end else begin
                want = pending_matches.pop_front();
                n_results++;
                if (want.found)
                    n_found++;
                if (o_match_found !== want.found) begin
                    $error("match_found: expected %0d, got %0d", want.found, o_match_found);
                    n_errors++;
                end
                if (o_match_index !== want.idx) begin
                    $error("match_index: expected %0d, got %0d", want.idx, o_match_index);
                    n_errors++;
                end
                if (o_best_distance !== want.best) begin
                    $error("best_distance: expected %0d, got %0d", want.best, o_best_distance);
                    n_errors++;
                end
                if (o_second_distance !== want.second) begin
                    $error("second_distance: expected %0d, got %0d",
                           want.second, o_second_distance);
                    n_errors++;
                end
            end
        end
    end

    // Directed table: typed results only where obvious, the rest from the predictor
    function automatic t_dir_row row(input t_cmd c, input logic [DESC_BITS-1:0] d,
                                     input int ix, input bit tk, input bit lst,
                                     input bit typed, input t_match want);
        t_dir_row r;
        r.w.cmd   = c;
        r.w.desc  = d;
        r.w.idx   = IDX_W'(ix);
        r.w.taken = tk;
        r.w.last  = lst;
        r.typed   = typed;
        r.want    = want;
        return r;
    endfunction

    initial begin
        logic [DESC_BITS-1:0] alt;
        logic [DESC_BITS-1:0] ones;
        logic [CFG_DATA_W-1:0] limits[6][2];

        n_errors = 0;
        n_words = 0;
        n_results = 0;
        n_found = 0;
        n_settings = 0;
        in_idle_on = 1'b1;
        held_query = '0;
        clear_bests();
        lim_dist  = MAX_DIST_RESET;
        lim_ratio = RATIO_RESET;

        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_addr   = REG_MAX_DIST;
        i_cfg_data   = '0;
        i_valid      = 1'b0;
        i_command    = CMD_LOAD;
        i_desc_word0 = '0;
        i_desc_word1 = '0;
        i_desc_word2 = '0;
        i_desc_word3 = '0;
        i_cand_index = '0;
        i_cand_taken = 1'b0;
        i_last       = 1'b0;

        ones = '1;
        alt  = {(DESC_BITS / 2){2'b01}};

        // Exact match after reset, against the all-zero query
        dir_tab = {dir_tab, row(CMD_CAND, '0, 5, 0, 1, 1, '{1'b1, 12'd5, 9'd0, 9'd256})};
        // Load with junk in the ignored fields
        dir_tab = {dir_tab, row(CMD_LOAD, ones, 4095, 1, 1, 0, '0)};
        // Distance 256 never becomes a best
        dir_tab = {dir_tab, row(CMD_CAND, '0, 7, 0, 1, 1, '{1'b0, 12'd0, 9'd256, 9'd256})};
        // Taken last with nothing gathered
        dir_tab = {dir_tab, row(CMD_CAND, ones, 9, 1, 1, 1, '{1'b0, 12'd0, 9'd256, 9'd256})};
        // Best at top index, runner-up at one bit, taken last reports them
        dir_tab = {dir_tab, row(CMD_CAND, ones, 4095, 0, 0, 0, '0)};
        dir_tab = {dir_tab, row(CMD_CAND, ones ^ 256'd1, 1, 0, 0, 0, '0)};
        dir_tab = {dir_tab, row(CMD_CAND, ones, 2, 1, 1, 1, '{1'b1, 12'd4095, 9'd0, 9'd1})};
        // Tie keeps the earlier index and fails the ratio test
        dir_tab = {dir_tab, row(CMD_CAND, ones, 3, 0, 0, 0, '0)};
        dir_tab = {dir_tab, row(CMD_CAND, ones, 9, 0, 1, 1, '{1'b0, 12'd3, 9'd0, 9'd0})};
        // Alternating query; threshold one above max_distance
        dir_tab = {dir_tab, row(CMD_LOAD, alt, 0, 0, 0, 0, '0)};
        dir_tab = {dir_tab, row(CMD_CAND, ~alt, 100, 0, 0, 0, '0)};
        dir_tab = {dir_tab, row(CMD_CAND, alt ^ ((256'd1 << 51) - 256'd1), 11, 0, 0, 0, '0)};
        dir_tab = {dir_tab, row(CMD_CAND, alt, 0, 1, 1, 1, '{1'b0, 12'd11, 9'd51, 9'd256})};
        // Ratio boundary: 50 against 67 passes, 50 against 66 fails
        dir_tab = {dir_tab, row(CMD_CAND, alt ^ ((256'd1 << 50) - 256'd1), 12, 0, 0, 0, '0)};
        dir_tab = {dir_tab, row(CMD_CAND, alt ^ ((256'd1 << 67) - 256'd1), 13, 0, 1, 1,
                                '{1'b1, 12'd12, 9'd50, 9'd67})};
        dir_tab = {dir_tab, row(CMD_CAND, alt ^ ((256'd1 << 50) - 256'd1), 14, 0, 0, 0, '0)};
        dir_tab = {dir_tab, row(CMD_CAND, alt ^ ((256'd1 << 66) - 256'd1), 15, 0, 1, 1,
                                '{1'b0, 12'd14, 9'd50, 9'd66})};
        // Load in mid-group drops the bests gathered so far
        dir_tab = {dir_tab, row(CMD_CAND, alt ^ 256'h3FF, 20, 0, 0, 0, '0)};
        dir_tab = {dir_tab, row(CMD_LOAD, '0, 0, 0, 0, 0, '0)};
        dir_tab = {dir_tab, row(CMD_CAND, '0, 21, 1, 1, 1, '{1'b0, 12'd0, 9'd256, 9'd256})};
        // Patterned words, checked by the predictor
        dir_tab = {dir_tab, row(CMD_CAND, {(DESC_BITS / 8){8'h0F}}, 2048, 0, 0, 0, '0)};
        dir_tab = {dir_tab, row(CMD_CAND, {(DESC_BITS / 16){16'hFF00}}, 1024, 0, 1, 0, '0)};

        // Hold reset, then release it on a falling edge
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i])
            send_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].want);
        drain();

        // Register settings per random phase, extremes included
        limits[0] = '{9'd50, 9'd192};
        limits[1] = '{9'd0, 9'd0};
        limits[2] = '{9'd256, 9'd256};
        limits[3] = '{9'd511, 9'd511};
        limits[4] = '{CFG_DATA_W'($urandom_range(20, 80)), CFG_DATA_W'($urandom_range(150, 256))};
        limits[5] = '{CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom())};
        for (int p = 0; p < 6; p++) begin
            set_limits(limits[p][0], limits[p][1]);
            run_groups(205);
            drain();
        end

        foreach (pending_matches[i]) begin
            $error("result never arrived: found %0d index %0d best %0d second %0d",
                   pending_matches[i].found, pending_matches[i].idx,
                   pending_matches[i].best, pending_matches[i].second);
            n_errors++;
        end

        $display("Ran %0d input words over %0d register settings plus reset values.",
                 n_words, n_settings);
        $display("Checked %0d result words, %0d of them reporting a match.", n_results, n_found);
        if (n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
